// ===== hw/rtl/kdlpr_pkg.sv =====
// Package for the key debounce block: register indexes, event codes and
// shared widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kdlpr_pkg;

    // Number of logical keys: pin one alone, pin two alone, both pins
    localparam int KEY_NUM = 3;
    // Two event slots per key, though only a held key gives two in one tick
    localparam int MAX_EVENTS = 2 * KEY_NUM;

    typedef logic [3:0] evt_code_t;
    typedef logic [2:0] evt_cnt_t;
    typedef logic [3:0] cfg_idx_t;

    // Configuration register indexes
    localparam cfg_idx_t REG_LONG_K1      = 4'd0;
    localparam cfg_idx_t REG_LONG_K2      = 4'd1;
    localparam cfg_idx_t REG_LONG_COMBO   = 4'd2;
    localparam cfg_idx_t REG_REPEAT_K1    = 4'd3;
    localparam cfg_idx_t REG_REPEAT_K2    = 4'd4;
    localparam cfg_idx_t REG_REPEAT_COMBO = 4'd5;
    localparam cfg_idx_t REG_ACTIVE_LVL   = 4'd6;
    localparam cfg_idx_t REG_FAST_MODE    = 4'd7;

    // Event codes per key: press or repeat, release, long press
    localparam evt_code_t PRESS_CODE   [KEY_NUM] = '{4'd1, 4'd4, 4'd7};
    localparam evt_code_t RELEASE_CODE [KEY_NUM] = '{4'd2, 4'd5, 4'd8};
    localparam evt_code_t LONG_CODE    [KEY_NUM] = '{4'd3, 4'd6, 4'd9};

    localparam logic [15:0] LONG_RESET   = 16'd100;
    localparam logic [7:0]  REPEAT_RESET = 8'd0;

endpackage

`default_nettype wire

// ===== hw/rtl/key_debounce_long_press_repeat.sv =====
// Top level of the key debounce block with long press and auto-repeat.
// Depends on kdlpr_pkg for register indexes, event codes and types.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   s_ channel: one scan tick per item, two raw pin levels (bit0 pin one).
//   m_ channel: event items, one per cycle while m_ready is high; m_last_event
//   marks the final event of a tick. Keys are pin one alone, pin two alone and
//   both pins; events come in key order, press before long press within a key.
//   cfg_ port: plain write, index per the register list, no read-back.
//   Latency: a tick's first event is valid the cycle after the tick is
//   taken. A tick that gives no event leaves no trace on m_.
//   Throughput: the queue sends one event per cycle while m_ready is high;
//   the next tick is taken in the cycle the last event of a tick leaves,
//   and a tick that gives no event leaves s_ready high.
//   All debounce, hold and repeat state updates in the cycle a tick is
//   taken.
//   Reset (aresetn low, synchronous): long press 100 ticks, repeat off,
//   active level low, fast mode off, filters at half the filter time,
//   all keys released, output queue empty.
//   When m_ready stays low the queued event holds and s_ready stays low
//   until the queue drains.
module key_debounce_long_press_repeat #(
    parameter int FILTER_TICKS = 5
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Tick input
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_pin_levels,
    // Event output
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [3:0]      m_event_code,
    output logic            m_last_event,
    // Configuration write
    input  wire logic       cfg_wr_en,
    input  wire logic [3:0] cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    localparam int KN = kdlpr_pkg::KEY_NUM;
    localparam int ME = kdlpr_pkg::MAX_EVENTS;
    localparam logic [3:0] FILT      = 4'(FILTER_TICKS);
    localparam logic [3:0] FILT_2X   = 4'(2 * FILTER_TICKS);
    localparam logic [3:0] FILT_HALF = 4'(FILTER_TICKS / 2);

    // Configuration registers
    logic [15:0] long_reg   [KN];
    logic [7:0]  repeat_reg [KN];
    logic [1:0]  active_lvl_reg;
    logic        fast_mode_reg;

    // Per-key state
    logic [3:0]  filt_reg  [KN];
    logic [3:0]  filt_next [KN];
    logic        pressed_reg  [KN];
    logic        pressed_next [KN];
    logic [15:0] hold_reg  [KN];
    logic [15:0] hold_next [KN];
    logic [7:0]  rep_reg   [KN];
    logic [7:0]  rep_next  [KN];

    // Event queue for the tick in flight
    kdlpr_pkg::evt_code_t queue_reg  [ME];
    kdlpr_pkg::evt_code_t queue_next [ME];
    kdlpr_pkg::evt_cnt_t  cnt_reg;
    kdlpr_pkg::evt_cnt_t  cnt_next;
    kdlpr_pkg::evt_cnt_t  rd_idx_reg;

    // Two event slots per key: first is press or release, second is long or repeat
    logic                 slot_vld  [ME];
    kdlpr_pkg::evt_code_t slot_code [ME];

    logic [1:0] act;
    logic [KN-1:0] down;
    logic in_fire;
    logic out_fire;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign m_valid  = (cnt_reg != '0);
    assign s_ready  = (cnt_reg == '0) || ((cnt_reg == 3'd1) && m_ready);
    assign m_event_code = queue_reg[rd_idx_reg];
    assign m_last_event = (cnt_reg == 3'd1);

    // Decode the three logical keys from the pin levels
    assign act     = ~(s_pin_levels ^ active_lvl_reg);
    assign down[0] = (act == 2'b01);
    assign down[1] = (act == 2'b10);
    assign down[2] = (act == 2'b11);

    // Debounce, hold and repeat update for every key
    always_comb begin
        logic        do_held;
        logic        do_rel;
        logic [15:0] hold_inc;
        logic [7:0]  rep_inc;
        for (int k = 0; k < KN; k++) begin
            filt_next[k]    = filt_reg[k];
            pressed_next[k] = pressed_reg[k];
            hold_next[k]    = hold_reg[k];
            rep_next[k]     = rep_reg[k];
            slot_vld[2*k]    = 1'b0;
            slot_code[2*k]   = kdlpr_pkg::PRESS_CODE[k];
            slot_vld[2*k+1]  = 1'b0;
            slot_code[2*k+1] = kdlpr_pkg::LONG_CODE[k];
            do_held = 1'b0;
            do_rel  = 1'b0;

            if (fast_mode_reg) begin
                if (down[k]) begin
                    do_held = 1'b1;
                end else begin
                    do_rel = 1'b1;
                end
            end else if (down[k]) begin
                if (filt_reg[k] < FILT) begin
                    filt_next[k] = FILT;
                end else if (filt_reg[k] < FILT_2X) begin
                    filt_next[k] = filt_reg[k] + 4'd1;
                end else begin
                    do_held = 1'b1;
                end
            end else begin
                if (filt_reg[k] > FILT) begin
                    filt_next[k] = FILT;
                end else if (filt_reg[k] != '0) begin
                    filt_next[k] = filt_reg[k] - 4'd1;
                end else begin
                    do_rel = 1'b1;
                end
            end

            // Clear hold and repeat on every inactive tick
            if (!down[k]) begin
                hold_next[k] = '0;
                rep_next[k]  = '0;
            end

            // Release event
            if (do_rel && pressed_reg[k]) begin
                pressed_next[k] = 1'b0;
                slot_vld[2*k]   = 1'b1;
                slot_code[2*k]  = kdlpr_pkg::RELEASE_CODE[k];
            end

            // Press, long press and auto-repeat
            hold_inc = hold_reg[k] + 16'd1;
            rep_inc  = rep_reg[k] + 8'd1;
            if (do_held) begin
                if (!pressed_reg[k]) begin
                    pressed_next[k] = 1'b1;
                    slot_vld[2*k]   = 1'b1;
                end
                if (long_reg[k] != '0) begin
                    if (hold_reg[k] < long_reg[k]) begin
                        hold_next[k] = hold_inc;
                        if (hold_inc == long_reg[k]) begin
                            slot_vld[2*k+1] = 1'b1;
                        end
                    end else if (repeat_reg[k] != '0) begin
                        if (rep_inc >= repeat_reg[k]) begin
                            rep_next[k]      = '0;
                            slot_vld[2*k+1]  = 1'b1;
                            slot_code[2*k+1] = kdlpr_pkg::PRESS_CODE[k];
                        end else begin
                            rep_next[k] = rep_inc;
                        end
                    end
                end
            end
        end
    end

    // Pack the valid slots into the queue in key order
    always_comb begin
        kdlpr_pkg::evt_cnt_t pos;
        pos = '0;
        for (int i = 0; i < ME; i++) begin
            queue_next[i] = '0;
        end
        for (int i = 0; i < ME; i++) begin
            if (slot_vld[i]) begin
                queue_next[pos] = slot_code[i];
                pos = pos + 3'd1;
            end
        end
        cnt_next = pos;
    end

    // Hold the queue and advance the read pointer one event per cycle while m_ready is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            rd_idx_reg <= '0;
        end else if (in_fire) begin
            cnt_reg    <= cnt_next;
            rd_idx_reg <= '0;
        end else if (out_fire) begin
            cnt_reg    <= cnt_reg - 3'd1;
            rd_idx_reg <= rd_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            queue_reg <= queue_next;
        end
    end

    // Key state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KN; k++) begin
                filt_reg[k]    <= FILT_HALF;
                pressed_reg[k] <= 1'b0;
                hold_reg[k]    <= '0;
                rep_reg[k]     <= '0;
                long_reg[k]    <= kdlpr_pkg::LONG_RESET;
                repeat_reg[k]  <= kdlpr_pkg::REPEAT_RESET;
            end
            active_lvl_reg <= '0;
            fast_mode_reg  <= 1'b0;
        end else begin
            if (in_fire) begin
                filt_reg    <= filt_next;
                pressed_reg <= pressed_next;
                hold_reg    <= hold_next;
                rep_reg     <= rep_next;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    kdlpr_pkg::REG_LONG_K1: begin
                        long_reg[0] <= cfg_wdata;
                        rep_reg[0]  <= '0;
                    end
                    kdlpr_pkg::REG_LONG_K2: begin
                        long_reg[1] <= cfg_wdata;
                        rep_reg[1]  <= '0;
                    end
                    kdlpr_pkg::REG_LONG_COMBO: begin
                        long_reg[2] <= cfg_wdata;
                        rep_reg[2]  <= '0;
                    end
                    kdlpr_pkg::REG_REPEAT_K1: begin
                        repeat_reg[0] <= cfg_wdata[7:0];
                        rep_reg[0]    <= '0;
                    end
                    kdlpr_pkg::REG_REPEAT_K2: begin
                        repeat_reg[1] <= cfg_wdata[7:0];
                        rep_reg[1]    <= '0;
                    end
                    kdlpr_pkg::REG_REPEAT_COMBO: begin
                        repeat_reg[2] <= cfg_wdata[7:0];
                        rep_reg[2]    <= '0;
                    end
                    kdlpr_pkg::REG_ACTIVE_LVL: begin
                        active_lvl_reg <= cfg_wdata[1:0];
                    end
                    kdlpr_pkg::REG_FAST_MODE: begin
                        fast_mode_reg <= cfg_wdata[0];
                    end
                    default: begin
                        // drop writes to unknown registers
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire
